// ===== sv/mlcs_pkg.sv =====
// Package with payload types and status codes for the linear congruence solver.
`default_nettype none

package mlcs_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned MOD_W = 31;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_SOLVED       = 2'd0,
    STATUS_ZERO_ZERO    = 2'd1,
    STATUS_ZERO_NONZERO = 2'd2,
    STATUS_NO_DIVIDE    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] a_value;
    logic signed [VAL_W-1:0] b_value;
    logic        [MOD_W-1:0] modulus;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [MOD_W-1:0]   solution;
    logic [MOD_W-1:0]   divisor;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/modular_linear_congruence_solver_top.sv =====
// Linear congruence solver a*x == b (mod m) built around one serial divider.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_ready   | in_data   (a_value, b_value, modulus)
//   out     | output    | out_valid/out_ready | out_data  (status, solution, divisor)
//
// Every division runs on one restoring divider, one quotient bit per cycle. An item
// first reduces a modulo m, then runs Euclid steps on (m, reduced a), divides b by the
// gcd, then forms the final product and reduces it modulo m; the path is far shorter
// when a reduces to zero. Reset is synchronous, active low. in_ready is high only
// between items; a stalled result waits in the output register while the next item
// is already accepted.
`default_nettype none

module modular_linear_congruence_solver_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mlcs_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mlcs_pkg::out_item_t    out_data
);

  localparam int unsigned MW    = mlcs_pkg::MOD_W;
  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned DQ_W  = VW + MW;
  localparam int unsigned CNT_W = $clog2(DQ_W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_AMOD, S_BMOD, S_EUCLID, S_BDIV, S_MUL, S_XMOD, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  mlcs_pkg::out_item_t out_data_r, out_data_nxt;

  // Datapath registers.
  logic [DQ_W-1:0]  dq_r, dq_nxt;      // dividend in, quotient out
  logic [MW-1:0]    rem_r, rem_nxt;
  logic [MW-1:0]    dsr_r, dsr_nxt;    // divisor
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0]    m_r, m_nxt;
  logic [VW-1:0]    b_mag_r, b_mag_nxt;
  logic             a_neg_r, a_neg_nxt;
  logic             b_neg_r, b_neg_nxt;
  logic [MW-1:0]    c0_r, c0_nxt;
  logic [MW-1:0]    c1_r, c1_nxt;
  logic             odd_r, odd_nxt;
  mlcs_pkg::out_item_t res_r, res_nxt;

  // Sign handling of the inputs.
  logic [VW-1:0] a_low, b_low, a_abs, b_abs;
  logic          a_sgn, b_sgn;

  assign a_low = in_data.a_value[VW-1:0];
  assign b_low = in_data.b_value[VW-1:0];
  assign a_sgn = a_low[VW-1];
  assign b_sgn = b_low[VW-1];
  assign a_abs = a_sgn ? VW'(~a_low + 1'b1) : a_low;
  assign b_abs = b_sgn ? VW'(~b_low + 1'b1) : b_low;

  // One restoring division step.
  logic [MW:0]   trial, diff;
  logic          ge;
  logic [MW-1:0] step_rem;

  assign trial    = {rem_r, dq_r[DQ_W-1]};
  assign ge       = (trial >= {1'b0, dsr_r});
  assign diff     = trial - {1'b0, dsr_r};
  assign step_rem = ge ? diff[MW-1:0] : trial[MW-1:0];

  // Continuant update and final product.
  logic [2*MW-1:0] cont_prod;
  logic [MW-1:0]   cont_sum;
  logic [DQ_W-1:0] fin_prod;
  logic [MW-1:0]   a_red, x_fix;
  logic            in_acc, div_busy;

  assign cont_prod = (2*MW)'(c1_r) * (2*MW)'(dq_r[MW-1:0]);
  assign cont_sum  = cont_prod[MW-1:0] + c0_r;
  assign fin_prod  = DQ_W'(dq_r[VW-1:0]) * DQ_W'(c1_r);
  assign a_red     = (a_neg_r && rem_r != '0) ? (m_r - rem_r) : rem_r;
  assign x_fix     = ((b_neg_r ^ odd_r) && rem_r != '0) ? (m_r - rem_r) : rem_r;
  assign in_acc    = in_valid && in_ready;
  assign div_busy  = (cnt_r != '0);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    b_mag_nxt     = b_mag_r;
    a_neg_nxt     = a_neg_r;
    b_neg_nxt     = b_neg_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    odd_nxt       = odd_r;
    res_nxt       = res_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_neg_nxt = a_sgn;
          b_neg_nxt = b_sgn;
          b_mag_nxt = b_abs;
          m_nxt     = in_data.modulus;
          if (in_data.modulus == '0) begin
            res_nxt.status   = mlcs_pkg::STATUS_ZERO_NONZERO;
            res_nxt.solution = '0;
            res_nxt.divisor  = '0;
            state_nxt        = S_FINISH;
          end else begin
            dq_nxt    = {a_abs, MW'(0)};
            dsr_nxt   = in_data.modulus;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(VW);
            state_nxt = S_AMOD;
          end
        end
      end

      S_AMOD: begin
        if (div_busy) begin
          rem_nxt = step_rem;
          dq_nxt  = {dq_r[DQ_W-2:0], ge};
          cnt_nxt = cnt_r - 1'b1;
        end else if (a_red == '0) begin
          dq_nxt    = {b_mag_r, MW'(0)};
          dsr_nxt   = m_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(VW);
          state_nxt = S_BMOD;
        end else begin
          // Euclid starts on (m, reduced a).
          dq_nxt    = {m_r, VW'(0)};
          dsr_nxt   = a_red;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(MW);
          c0_nxt    = '0;
          c1_nxt    = MW'(1);
          odd_nxt   = 1'b0;
          state_nxt = S_EUCLID;
        end
      end

      S_BMOD: begin
        if (div_busy) begin
          rem_nxt = step_rem;
          dq_nxt  = {dq_r[DQ_W-2:0], ge};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          res_nxt.status   = (rem_r == '0) ? mlcs_pkg::STATUS_ZERO_ZERO
                                           : mlcs_pkg::STATUS_ZERO_NONZERO;
          res_nxt.solution = '0;
          res_nxt.divisor  = m_r;
          state_nxt        = S_FINISH;
        end
      end

      S_EUCLID: begin
        if (div_busy) begin
          rem_nxt = step_rem;
          dq_nxt  = {dq_r[DQ_W-2:0], ge};
          cnt_nxt = cnt_r - 1'b1;
        end else if (rem_r != '0) begin
          // The quotient sits in the low bits of dq_r for the continuant step.
          odd_nxt = ~odd_r;
          c0_nxt  = c1_r;
          c1_nxt  = cont_sum;
          dq_nxt  = {dsr_r, VW'(0)};
          dsr_nxt = rem_r;
          rem_nxt = '0;
          cnt_nxt = CNT_W'(MW);
        end else begin
          // The divisor now holds the gcd.
          res_nxt.divisor = dsr_r;
          dq_nxt          = {b_mag_r, MW'(0)};
          rem_nxt         = '0;
          cnt_nxt         = CNT_W'(VW);
          state_nxt       = S_BDIV;
        end
      end

      S_BDIV: begin
        if (div_busy) begin
          rem_nxt = step_rem;
          dq_nxt  = {dq_r[DQ_W-2:0], ge};
          cnt_nxt = cnt_r - 1'b1;
        end else if (rem_r != '0) begin
          res_nxt.status   = mlcs_pkg::STATUS_NO_DIVIDE;
          res_nxt.solution = '0;
          state_nxt        = S_FINISH;
        end else begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        dq_nxt    = fin_prod;
        dsr_nxt   = m_r;
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(DQ_W);
        state_nxt = S_XMOD;
      end

      S_XMOD: begin
        if (div_busy) begin
          rem_nxt = step_rem;
          dq_nxt  = {dq_r[DQ_W-2:0], ge};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          res_nxt.status   = mlcs_pkg::STATUS_SOLVED;
          res_nxt.solution = x_fix;
          state_nxt        = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    dsr_r   <= dsr_nxt;
    cnt_r   <= cnt_nxt;
    m_r     <= m_nxt;
    b_mag_r <= b_mag_nxt;
    a_neg_r <= a_neg_nxt;
    b_neg_r <= b_neg_nxt;
    c0_r    <= c0_nxt;
    c1_r    <= c1_nxt;
    odd_r   <= odd_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire
